>>> rtl/fiir_pkg.sv
// Package for the fifth-order high-pass IIR filter: widths, Q24 coefficients
// and the fixed-point product functions. It depends on nothing else.
`timescale 1ns / 1ps

package fiir_pkg;

	localparam int Order     = 5;
	localparam int SampleW   = 16;
	localparam int CoefW     = 29;
	localparam int AccW      = 64;
	localparam int CoefShift = 24;
	localparam int InShift   = 12;
	localparam int OutShift  = 12;
	localparam int HalfW     = AccW / 2;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic signed [CoefW-1:0]   coef_t;
	typedef logic signed [AccW-1:0]    acc_t;

	// Feedforward coefficients b0..b5 in Q24.
	localparam coef_t FfCoef [Order+1] = '{
		29'sd13784738, -29'sd68575242, 29'sd136804081,
		-29'sd136804081, 29'sd68575242, -29'sd13784738
	};

	// Feedback coefficients a1..a5 in Q24; the leading coefficient is one.
	localparam coef_t FbCoef [Order] = '{
		-29'sd77062905, 29'sd141942076, -29'sd130942149,
		29'sd60446014, -29'sd11157762
	};

	// Floor of coef * (sample * 2^12) / 2^24. The product fits without wrap.
	function automatic acc_t ff_term(input coef_t c, input sample_t x);
		logic signed [CoefW+SampleW-1:0] p;
		logic signed [CoefW+SampleW-1:0] sh;
		p  = c * x;
		sh = p >>> (CoefShift - InShift);
		return AccW'(sh);
	endfunction

	// Floor of (coef * y mod 2^64) / 2^24, built from two half-width products.
	function automatic acc_t fb_term(input coef_t c, input acc_t y);
		logic signed [CoefW+HalfW:0]   lo;
		logic signed [CoefW+HalfW-1:0] hp;
		acc_t                          p;
		lo = c * $signed({1'b0, y[HalfW-1:0]});
		hp = c * $signed(y[AccW-1:HalfW]);
		p  = AccW'(lo) + {hp[HalfW-1:0], {HalfW{1'b0}}};
		return p >>> CoefShift;
	endfunction

endpackage

>>> rtl/fifth_order_iir_highpass_q24.sv
// Fifth-order high-pass IIR filter with Q24 coefficients, top level.
// An accepted input is held in sample_s1; its result is then registered in filtered_q.
// Throughput is one transaction per cycle while the output is not stalled.
// Reset clears the filter history and the valid flags of the input and result registers.
// Depends on fiir_pkg and fiir_core.
`timescale 1ns / 1ps

module fifth_order_iir_highpass_q24
	import fiir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SampleW-1:0]   sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SampleW-1:0]   filtered
);

	logic               valid_s1;
	sample_t            sample_s1;
	logic               advance;
	logic               out_valid_q;
	logic [SampleW-1:0] filtered_q;
	logic [SampleW-1:0] core_result;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	fiir_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.sample (sample_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filtered_q <= core_result;
		end
	end

endmodule

>>> rtl/fiir_core.sv
// Filter datapath and history for the fifth-order high-pass IIR filter, in
// transposed form with one feedback product in the recurrence. Uses fiir_pkg.
`timescale 1ns / 1ps

module fiir_core
	import fiir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  sample_t              sample,
	output logic [SampleW-1:0]   result
);

	acc_t y_q;
	acc_t part_q [Order];
	acc_t acc;
	acc_t part_d [Order];

	always_comb begin
		acc = ff_term(FfCoef[0], sample) + part_q[0] - fb_term(FbCoef[0], y_q);
		for (int k = 0; k < Order - 1; k++) begin
			part_d[k] = part_q[k+1] + ff_term(FfCoef[k+1], sample)
				- fb_term(FbCoef[k+1], y_q);
		end
		part_d[Order-1] = ff_term(FfCoef[Order], sample);
	end

	assign result = acc[OutShift+SampleW-1:OutShift];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0;
			for (int k = 0; k < Order; k++) begin
				part_q[k] <= '0;
			end
		end else if (en) begin
			y_q <= acc;
			for (int k = 0; k < Order; k++) begin
				part_q[k] <= part_d[k];
			end
		end
	end

endmodule

>>> tb/sv/fifth_order_iir_highpass_q24_test.sv
// Testbench for the fifth-order high-pass IIR filter: drives samples, predicts every result
// in 64-bit Q24 arithmetic and compares each output transaction as it is accepted.
// Depends on fiir_pkg and fifth_order_iir_highpass_q24.
`timescale 1ns / 1ps

module fifth_order_iir_highpass_q24_test
	import fiir_pkg::*;
();

	localparam int CycleLimit = 400000;
	localparam int RandomItems = 1800;

	localparam longint FfQ24 [Order+1] = '{
		64'sd13784738, -64'sd68575242, 64'sd136804081,
		-64'sd136804081, 64'sd68575242, -64'sd13784738
	};
	localparam longint FbQ24 [Order] = '{
		-64'sd77062905, 64'sd141942076, -64'sd130942149,
		64'sd60446014, -64'sd11157762
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [SampleW-1:0] sample;
	logic               out_valid;
	logic               out_stall;
	logic [SampleW-1:0] filtered;

	sample_t      hist_samples [Order];
	longint       hist_accums [Order];
	logic [15:0]  expected_filtered [$];
	int           mismatch_count = 0;
	int           cycle_count = 0;
	bit           calm;

	fifth_order_iir_highpass_q24 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filtered  (filtered)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint q24_product(input longint coef, input longint val);
		longint prod;
		prod = coef * val;
		return prod >>> CoefShift;
	endfunction

	function automatic logic [15:0] filter_predict(input sample_t x);
		longint acc;
		acc = q24_product(FfQ24[0], longint'(x) <<< InShift);
		for (int k = 1; k <= Order; k++) begin
			acc += q24_product(FfQ24[k], longint'(hist_samples[k-1]) <<< InShift);
			acc -= q24_product(FbQ24[k-1], hist_accums[k-1]);
		end
		for (int k = Order - 1; k > 0; k--) begin
			hist_samples[k] = hist_samples[k-1];
			hist_accums[k] = hist_accums[k-1];
		end
		hist_samples[0] = x;
		hist_accums[0] = acc;
		return acc[OutShift+15:OutShift];
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < 50) begin
			$display("mismatch at cycle %0d: %s, got %h, expected %h",
				cycle_count, what, got, want);
		end
		mismatch_count++;
	endtask

	task automatic send_sample(input logic [SampleW-1:0] raw);
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= raw;
		do @(posedge clk); while (in_stall);
		expected_filtered.push_back(filter_predict(sample_t'(raw)));
	endtask

	always @(posedge clk) begin : check_results
		logic [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_filtered.size() == 0) begin
				report_mismatch("result with none outstanding", filtered, 16'hxxxx);
			end else begin
				want = expected_filtered.pop_front();
				if (filtered !== want) begin
					report_mismatch("filtered", filtered, want);
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 14);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_extremes();
		send_sample(16'h0000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_sample(16'h0000);
	endtask

	task automatic test_impulse();
		send_sample(16'h7FFF);
		repeat (5) send_sample(16'h0000);
	endtask

	task automatic test_step();
		repeat (8) send_sample(16'h8000);
	endtask

	task automatic test_random_streams(input int total);
		int          sent;
		int          run;
		int          kind;
		logic [15:0] level;
		sent = 0;
		while (sent < total) begin
			kind = $urandom_range(4);
			run = $urandom_range(40, 4);
			level = 16'($urandom);
			for (int k = 0; k < run && sent < total; k++) begin
				calm = (sent >= total / 3) && (sent < total / 2);
				case (kind)
					0: send_sample(16'($urandom));
					1: send_sample(16'($urandom_range(64)) - 16'd32);
					2: send_sample(k[0] ? 16'h8000 : 16'h7FFF);
					3: send_sample(level);
					default: send_sample(level + 16'(k * 1024));
				endcase
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		for (int k = 0; k < Order; k++) begin
			hist_samples[k] = '0;
			hist_accums[k] = '0;
		end
		calm = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_impulse();
		test_step();
		test_random_streams(RandomItems);

		in_valid <= 1'b0;
		while (expected_filtered.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
